>>> rtl/ogds_pkg.sv
`timescale 1ns / 1ps

// Shared types and constants of the occupancy grid disc stamper.
package ogds_pkg;

  // Width of the signed cell coordinates on the request channel.
  localparam int unsigned COORD_W = 11;
  // Width of the mark count on the result channel.
  localparam int unsigned COUNT_W = 17;

  // Request codes.
  typedef enum logic [2:0] {
    REQ_WRITE   = 3'd0,
    REQ_STAMP   = 3'd1,
    REQ_CLEAR   = 3'd2,
    REQ_QUERY   = 3'd3,
    REQ_INFLATE = 3'd4
  } req_e;

  // Register indexes of the configuration port (word addresses).
  typedef enum logic [1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1,
    REG_OCC_LEVEL   = 2'd2,
    REG_NEGATE      = 2'd3
  } reg_e;

endpackage

>>> rtl/ogds_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module ogds_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/occupancy_grid_disc_stamper.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                   Payload
// request   in         in_valid_i / in_stall_o     req_type_i cell_x_i cell_y_i radius_i
//                                                  pixel_value_i
// result    out        out_valid_o / out_stall_i   occupied_o in_bounds_o mark_count_o
// config    in         psel penable pwrite pready  paddr pwdata prdata
//
// A pixel write passes through S_WR; an in-grid query reads the map and mark in S_Q_RD
// and decides in S_Q_CHK, one outside the grid goes straight to S_DONE. A stamp visits
// each cell of the disc square and adds a mark update step for each in-grid disc cell.
// An inflation copies all MAX_WIDTH*MAX_HEIGHT map entries into the seed store, scans
// each cell of the grid in use and fills the in-grid disc around every occupied seed cell.
// After reset, after a clear request and after a grid dimension write, a clearing pass
// runs over all MAX_WIDTH*MAX_HEIGHT mark memory entries; no request is taken meanwhile.
// in_stall_o is high while a transaction is in work; a finished result waits in the
// output register while out_stall_i is high, and the next request may then be taken.
module occupancy_grid_disc_stamper #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned MAX_RADIUS = 15
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Request channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [2:0]            req_type_i,
  input  logic signed [10:0]    cell_x_i,
  input  logic signed [10:0]    cell_y_i,
  input  logic [3:0]            radius_i,
  input  logic [7:0]            pixel_value_i,
  // Result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  occupied_o,
  output logic                  in_bounds_o,
  output logic [16:0]           mark_count_o,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int unsigned CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned XW    = $clog2(MAX_WIDTH);
  localparam int unsigned YW    = $clog2(MAX_HEIGHT);
  localparam int unsigned DW0   = ($clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1)) ?
                                  $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1);
  localparam int unsigned DIMW  = (DW0 > 9) ? DW0 : 9;
  localparam int unsigned CW    = ((DIMW > ogds_pkg::COORD_W) ? DIMW : ogds_pkg::COORD_W) + 2;
  localparam int unsigned RW    = $clog2(MAX_RADIUS + 1);
  localparam int unsigned OW    = RW + 1;

  // Sequencer states.
  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_CLR    = 12'b0000_0000_0010,
    S_WR     = 12'b0000_0000_0100,
    S_Q_RD   = 12'b0000_0000_1000,
    S_Q_CHK  = 12'b0000_0001_0000,
    S_ST_RD  = 12'b0000_0010_0000,
    S_ST_WR  = 12'b0000_0100_0000,
    S_CP     = 12'b0000_1000_0000,
    S_SC_RD  = 12'b0001_0000_0000,
    S_SC_CHK = 12'b0010_0000_0000,
    S_IF_WR  = 12'b0100_0000_0000,
    S_DONE   = 12'b1000_0000_0000
  } state_e;

  // Configuration registers.
  logic [8:0] grid_width_q, grid_width_d;
  logic [8:0] grid_height_q, grid_height_d;
  logic [7:0] occ_level_q, occ_level_d;
  logic       negate_q, negate_d;

  // Control state.
  state_e                  state_q, state_d;
  logic [AW-1:0]           cnt_q, cnt_d;
  logic                    cp_v_q, cp_v_d;
  logic                    clr_pend_q, clr_pend_d;
  logic                    clr_resp_q, clr_resp_d;
  logic [ogds_pkg::COUNT_W-1:0] total_q, total_d;
  logic                    out_valid_q, out_valid_d;

  // Working payload.
  logic signed [CW-1:0]    cx_q, cx_d, cy_q, cy_d;
  logic signed [OW-1:0]    dx_q, dx_d, dy_q, dy_d;
  logic [RW-1:0]           r_q, r_d;
  logic [7:0]              pix_q, pix_d;
  logic                    ib_q, ib_d, occ_q, occ_d;
  logic [AW-1:0]           cp_addr_q;
  logic                    res_occ_q, res_occ_d, res_ib_q, res_ib_d;
  logic [ogds_pkg::COUNT_W-1:0] res_cnt_q, res_cnt_d;

  // Memory ports.
  logic          map_we, mark_we, seed_we;
  logic [AW-1:0] map_raddr, mark_waddr;
  logic [7:0]    map_wdata, map_rdata, seed_rdata;
  logic          mark_wdata, mark_rdata;

  // Derived values.
  logic [DIMW-1:0]      eff_w, eff_h;
  logic signed [CW-1:0] pt_x, pt_y, in_x, in_y;
  logic [AW-1:0]        pt_addr;
  logic                 pt_inside, in_inside;
  logic signed [OW-1:0] r_s;
  logic [RW-1:0]        dx_abs, dy_abs;
  logic [2*RW-1:0]      dx_sq, dy_sq, r_sq;
  logic [2*RW:0]        d_sum;
  logic                 in_disc, cell_ok, disc_last, scan_last;
  logic [7:0]           fill;
  logic [RW-1:0]        r_in;
  logic                 cfg_wr, in_acc;
  logic                 out_load;

  // Point lies within the grid in use.
  function automatic logic inside_grid(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                       logic [DIMW-1:0] w, logic [DIMW-1:0] h);
    logic ok_x, ok_y;
    ok_x = !x[CW-1] && (x[CW-2:0] < (CW-1)'(w));
    ok_y = !y[CW-1] && (y[CW-2:0] < (CW-1)'(h));
    return ok_x && ok_y;
  endfunction

  // Pixel counts as occupied by its level.
  function automatic logic level_occ(logic [7:0] p, logic neg, logic [7:0] lvl);
    logic [7:0] v;
    v = neg ? ~p : p;
    return v < lvl;
  endfunction

  // Effective grid size, saturated to the storage size.
  assign eff_w = (DIMW'(grid_width_q) > DIMW'(MAX_WIDTH)) ? DIMW'(MAX_WIDTH)
                                                         : DIMW'(grid_width_q);
  assign eff_h = (DIMW'(grid_height_q) > DIMW'(MAX_HEIGHT)) ? DIMW'(MAX_HEIGHT)
                                                            : DIMW'(grid_height_q);

  // Current point: centre or scan position plus the disc offset.
  assign pt_x = cx_q + {{(CW - OW){dx_q[OW-1]}}, dx_q};
  assign pt_y = cy_q + {{(CW - OW){dy_q[OW-1]}}, dy_q};
  assign pt_inside = inside_grid(pt_x, pt_y, eff_w, eff_h);
  assign pt_addr = AW'(pt_y[YW-1:0]) * AW'(MAX_WIDTH) + AW'(pt_x[XW-1:0]);

  // Requested point, for the bounds flag.
  assign in_x = {{(CW - ogds_pkg::COORD_W){cell_x_i[10]}}, cell_x_i};
  assign in_y = {{(CW - ogds_pkg::COORD_W){cell_y_i[10]}}, cell_y_i};
  assign in_inside = inside_grid(in_x, in_y, eff_w, eff_h);

  // Disc membership test: dx*dx + dy*dy <= r*r.
  assign r_s    = $signed({1'b0, r_q});
  assign dx_abs = dx_q[OW-1] ? RW'(-dx_q) : RW'(dx_q);
  assign dy_abs = dy_q[OW-1] ? RW'(-dy_q) : RW'(dy_q);
  assign dx_sq  = (2*RW)'(dx_abs) * (2*RW)'(dx_abs);
  assign dy_sq  = (2*RW)'(dy_abs) * (2*RW)'(dy_abs);
  assign r_sq   = (2*RW)'(r_q) * (2*RW)'(r_q);
  assign d_sum  = (2*RW+1)'(dx_sq) + (2*RW+1)'(dy_sq);
  assign in_disc = d_sum <= (2*RW+1)'(r_sq);
  assign cell_ok = in_disc && pt_inside;
  assign disc_last = (dx_q == r_s) && (dy_q == r_s);
  assign scan_last = (cx_q == CW'(eff_w) - CW'(1)) && (cy_q == CW'(eff_h) - CW'(1));

  assign fill = {8{negate_q}};
  assign r_in = ({28'd0, radius_i} > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_i);

  // Handshakes.
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign in_stall_o = (state_q != S_IDLE) || clr_pend_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  assign pready     = 1'b1;

  // Register read-back.
  always_comb begin
    case (ogds_pkg::reg_e'(paddr[3:2]))
      ogds_pkg::REG_GRID_WIDTH:  prdata = {23'd0, grid_width_q};
      ogds_pkg::REG_GRID_HEIGHT: prdata = {23'd0, grid_height_q};
      ogds_pkg::REG_OCC_LEVEL:   prdata = {24'd0, occ_level_q};
      ogds_pkg::REG_NEGATE:      prdata = {31'd0, negate_q};
      default:                   prdata = 32'd0;
    endcase
  end

  // Sequencer and datapath next state.
  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    cp_v_d        = (state_q == S_CP);
    clr_pend_d    = clr_pend_q;
    clr_resp_d    = clr_resp_q;
    total_d       = total_q;
    cx_d          = cx_q;
    cy_d          = cy_q;
    dx_d          = dx_q;
    dy_d          = dy_q;
    r_d           = r_q;
    pix_d         = pix_q;
    ib_d          = ib_q;
    occ_d         = occ_q;
    grid_width_d  = grid_width_q;
    grid_height_d = grid_height_q;
    occ_level_d   = occ_level_q;
    negate_d      = negate_q;
    res_occ_d     = res_occ_q;
    res_ib_d      = res_ib_q;
    res_cnt_d     = res_cnt_q;
    map_we        = 1'b0;
    map_wdata     = fill;
    map_raddr     = pt_addr;
    mark_we       = 1'b0;
    mark_waddr    = pt_addr;
    mark_wdata    = 1'b0;

    // Configuration writes; a dimension change drops all dynamic marks.
    if (cfg_wr) begin
      case (ogds_pkg::reg_e'(paddr[3:2]))
        ogds_pkg::REG_GRID_WIDTH: begin
          grid_width_d = pwdata[8:0];
          clr_pend_d   = 1'b1;
          total_d      = '0;
        end
        ogds_pkg::REG_GRID_HEIGHT: begin
          grid_height_d = pwdata[8:0];
          clr_pend_d    = 1'b1;
          total_d       = '0;
        end
        ogds_pkg::REG_OCC_LEVEL: occ_level_d = pwdata[7:0];
        ogds_pkg::REG_NEGATE:    negate_d    = pwdata[0];
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (clr_pend_q) begin
          clr_pend_d = 1'b0;
          clr_resp_d = 1'b0;
          cnt_d      = '0;
          state_d    = S_CLR;
        end else if (in_acc) begin
          cx_d  = in_x;
          cy_d  = in_y;
          dx_d  = '0;
          dy_d  = '0;
          r_d   = r_in;
          pix_d = pixel_value_i;
          ib_d  = 1'b0;
          occ_d = 1'b0;
          case (ogds_pkg::req_e'(req_type_i))
            ogds_pkg::REQ_WRITE: begin
              ib_d    = in_inside;
              state_d = S_WR;
            end
            ogds_pkg::REQ_STAMP: begin
              ib_d    = in_inside;
              dx_d    = -$signed({1'b0, r_in});
              dy_d    = -$signed({1'b0, r_in});
              state_d = S_ST_RD;
            end
            ogds_pkg::REQ_CLEAR: begin
              total_d    = '0;
              clr_resp_d = 1'b1;
              cnt_d      = '0;
              state_d    = S_CLR;
            end
            ogds_pkg::REQ_QUERY: begin
              ib_d    = in_inside;
              occ_d   = !in_inside;
              state_d = in_inside ? S_Q_RD : S_DONE;
            end
            ogds_pkg::REQ_INFLATE: begin
              cx_d  = '0;
              cy_d  = '0;
              cnt_d = '0;
              if (r_in == '0 || eff_w == '0 || eff_h == '0) begin
                state_d = S_DONE;
              end else begin
                state_d = S_CP;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      // Clearing pass over the mark memory.
      S_CLR: begin
        mark_we    = 1'b1;
        mark_waddr = cnt_q;
        cnt_d      = cnt_q + AW'(1);
        if (cnt_q == AW'(CELLS - 1)) begin
          state_d = clr_resp_q ? S_DONE : S_IDLE;
        end
      end

      // Pixel write.
      S_WR: begin
        map_we    = ib_q;
        map_wdata = pix_q;
        state_d   = S_DONE;
      end

      // Query: read map and mark, then decide.
      S_Q_RD: state_d = S_Q_CHK;
      S_Q_CHK: begin
        occ_d   = mark_rdata || level_occ(map_rdata, negate_q, occ_level_q);
        state_d = S_DONE;
      end

      // Stamp: read the mark of each in-grid disc cell, set it when clear.
      S_ST_RD: begin
        if (cell_ok) begin
          state_d = S_ST_WR;
        end else if (disc_last) begin
          state_d = S_DONE;
        end else if (dx_q == r_s) begin
          dx_d = -r_s;
          dy_d = dy_q + OW'(1);
        end else begin
          dx_d = dx_q + OW'(1);
        end
      end
      S_ST_WR: begin
        mark_we    = !mark_rdata;
        mark_wdata = 1'b1;
        if (!mark_rdata) begin
          total_d = total_q + ogds_pkg::COUNT_W'(1);
        end
        if (disc_last) begin
          state_d = S_DONE;
        end else begin
          state_d = S_ST_RD;
          if (dx_q == r_s) begin
            dx_d = -r_s;
            dy_d = dy_q + OW'(1);
          end else begin
            dx_d = dx_q + OW'(1);
          end
        end
      end

      // Inflation: copy the map into the seed store, one entry a cycle.
      S_CP: begin
        map_raddr = cnt_q;
        cnt_d     = cnt_q + AW'(1);
        if (cnt_q == AW'(CELLS - 1)) begin
          state_d = S_SC_RD;
        end
      end

      // Scan the grid for seed cells.
      S_SC_RD: state_d = S_SC_CHK;
      S_SC_CHK: begin
        if (mark_rdata || level_occ(seed_rdata, negate_q, occ_level_q)) begin
          dx_d    = -r_s;
          dy_d    = -r_s;
          state_d = S_IF_WR;
        end else if (scan_last) begin
          state_d = S_DONE;
        end else begin
          state_d = S_SC_RD;
          if (cx_q == CW'(eff_w) - CW'(1)) begin
            cx_d = '0;
            cy_d = cy_q + CW'(1);
          end else begin
            cx_d = cx_q + CW'(1);
          end
        end
      end

      // Write the fill value over the disc around a seed cell.
      S_IF_WR: begin
        map_we = cell_ok;
        if (disc_last) begin
          dx_d = '0;
          dy_d = '0;
          if (scan_last) begin
            state_d = S_DONE;
          end else begin
            state_d = S_SC_RD;
            if (cx_q == CW'(eff_w) - CW'(1)) begin
              cx_d = '0;
              cy_d = cy_q + CW'(1);
            end else begin
              cx_d = cx_q + CW'(1);
            end
          end
        end else if (dx_q == r_s) begin
          dx_d = -r_s;
          dy_d = dy_q + OW'(1);
        end else begin
          dx_d = dx_q + OW'(1);
        end
      end

      // Hand the result to the output register.
      S_DONE: begin
        if (out_load) begin
          res_occ_d = occ_q;
          res_ib_d  = ib_q;
          res_cnt_d = total_q;
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Output register.
  assign out_valid_d  = out_load || (out_valid_q && out_stall_i);
  assign out_valid_o  = out_valid_q;
  assign occupied_o   = res_occ_q;
  assign in_bounds_o  = res_ib_q;
  assign mark_count_o = res_cnt_q;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cnt_q         <= '0;
      cp_v_q        <= 1'b0;
      clr_pend_q    <= 1'b1;
      clr_resp_q    <= 1'b0;
      total_q       <= '0;
      out_valid_q   <= 1'b0;
      grid_width_q  <= 9'd256;
      grid_height_q <= 9'd256;
      occ_level_q   <= 8'd166;
      negate_q      <= 1'b0;
    end else begin
      state_q       <= state_d;
      cnt_q         <= cnt_d;
      cp_v_q        <= cp_v_d;
      clr_pend_q    <= clr_pend_d;
      clr_resp_q    <= clr_resp_d;
      total_q       <= total_d;
      out_valid_q   <= out_valid_d;
      grid_width_q  <= grid_width_d;
      grid_height_q <= grid_height_d;
      occ_level_q   <= occ_level_d;
      negate_q      <= negate_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cx_q      <= cx_d;
    cy_q      <= cy_d;
    dx_q      <= dx_d;
    dy_q      <= dy_d;
    r_q       <= r_d;
    pix_q     <= pix_d;
    ib_q      <= ib_d;
    occ_q     <= occ_d;
    cp_addr_q <= cnt_q;
    res_occ_q <= res_occ_d;
    res_ib_q  <= res_ib_d;
    res_cnt_q <= res_cnt_d;
  end

  // The seed entry is written in the cycle after its map read.
  assign seed_we = cp_v_q;

  // Map store.
  ogds_ram #(
    .WIDTH (8),
    .DEPTH (CELLS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (pt_addr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  // Seed copy of the map used during inflation.
  ogds_ram #(
    .WIDTH (8),
    .DEPTH (CELLS)
  ) u_seed_ram (
    .clk_i   (clk_i),
    .we_i    (seed_we),
    .waddr_i (cp_addr_q),
    .wdata_i (map_rdata),
    .raddr_i (pt_addr),
    .rdata_o (seed_rdata)
  );

  // Dynamic obstacle marks.
  ogds_ram #(
    .WIDTH (1),
    .DEPTH (CELLS)
  ) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (mark_we),
    .waddr_i (mark_waddr),
    .wdata_i (mark_wdata),
    .raddr_i (pt_addr),
    .rdata_o (mark_rdata)
  );

endmodule
